// ===== rtl/slpd_pkg.sv =====
package slpd_pkg;

    // Frame buffer size and header layout
    localparam int FRAME_BYTES    = 256;
    localparam int HEADER_BYTES   = 6;
    localparam int POSITION_LIMIT = 250;

    // Largest payload that fits both the frame buffer and the 8-bit offset
    localparam int ROOM_BYTES = (FRAME_BYTES - HEADER_BYTES < POSITION_LIMIT)
                                ? (FRAME_BYTES - HEADER_BYTES) : POSITION_LIMIT;
    localparam logic [7:0] LIMIT_CAP = 8'(ROOM_BYTES);

    localparam logic [8:0] HEADER_LEN    = 9'(HEADER_BYTES);
    localparam logic [7:0] LEN_LO_OFFSET = 8'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Configuration reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd85;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd250;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC2   = 2'd1,
        PH_HEADER  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] limit;
    } t_cfg;

    typedef struct packed {
        logic       taken;
        logic [7:0] position;
        logic [7:0] value;
        logic       done;
        logic [8:0] length;
        logic       dropped;
    } t_result;

    // Saturate the written payload limit to what the frame can hold
    function automatic logic [7:0] sat_limit(input logic [7:0] value);
        logic [7:0] res;
        res = (value > LIMIT_CAP) ? LIMIT_CAP : value;
        return res;
    endfunction

endpackage

// ===== rtl/slpd_cfg.sv =====
module slpd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output slpd_pkg::t_cfg    o_cfg
);
    import slpd_pkg::*;

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_limit;

    assign o_cfg_ready = 1'b1;

    // Write registers; keep the payload limit already saturated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_limit       <= sat_limit(MAX_PAYLOAD_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_limit       <= sat_limit(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg.sync_first  = r_sync_first;
    assign o_cfg.sync_second = r_sync_second;
    assign o_cfg.limit       = r_limit;

endmodule

// ===== rtl/slpd_core.sv =====
module slpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  slpd_pkg::t_cfg      i_cfg,
    output slpd_pkg::t_result   o_result
);
    import slpd_pkg::*;

    t_phase     r_phase,    n_phase;
    logic [8:0] r_position, n_position;
    logic [7:0] r_len_lo,   n_len_lo;
    logic [8:0] r_end,      n_end;

    logic [8:0]  w_pos_inc;
    logic [15:0] w_len;
    logic        w_header_end;
    logic        w_len_zero;
    logic        w_len_ok;
    logic        w_payload_end;

    // Shared decode of the current word
    assign w_pos_inc     = r_position + 9'd1;
    assign w_len         = {i_byte, r_len_lo};
    assign w_header_end  = (w_pos_inc >= HEADER_LEN);
    assign w_len_zero    = (w_len == 16'd0);
    assign w_len_ok      = (w_len <= {8'd0, i_cfg.limit});
    assign w_payload_end = (w_pos_inc >= r_end);

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_len_lo   = r_len_lo;
        n_end      = r_end;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.sync_first) begin
                    n_phase    = PH_SYNC2;
                    n_position = 9'd1;
                end
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_phase    = PH_HEADER;
                    n_position = 9'd2;
                end else begin
                    n_phase    = PH_HUNT;
                    n_position = 9'd0;
                end
            end
            PH_HEADER: begin
                n_position = w_pos_inc;
                if (r_position[7:0] == LEN_LO_OFFSET) begin
                    n_len_lo = i_byte;
                end
                if (w_header_end) begin
                    if (!w_len_zero && w_len_ok) begin
                        n_phase = PH_PAYLOAD;
                        n_end   = HEADER_LEN + {1'b0, w_len[7:0]};
                    end else begin
                        n_phase    = PH_HUNT;
                        n_position = 9'd0;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_position = w_pos_inc;
                if (w_payload_end) begin
                    n_phase    = PH_HUNT;
                    n_position = 9'd0;
                end
            end
            default: begin
                n_phase    = PH_HUNT;
                n_position = 9'd0;
            end
        endcase
    end

    // Result for the current word
    always_comb begin
        o_result = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.sync_first) begin
                    o_result.taken    = 1'b1;
                    o_result.position = 8'd0;
                    o_result.value    = i_byte;
                end
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    o_result.taken    = 1'b1;
                    o_result.position = 8'd1;
                    o_result.value    = i_byte;
                end
            end
            PH_HEADER: begin
                o_result.taken    = 1'b1;
                o_result.position = r_position[7:0];
                o_result.value    = i_byte;
                if (w_header_end) begin
                    if (w_len_zero) begin
                        o_result.done   = 1'b1;
                        o_result.length = w_pos_inc;
                    end else if (!w_len_ok) begin
                        o_result.dropped = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_result.taken    = 1'b1;
                o_result.position = r_position[7:0];
                o_result.value    = i_byte;
                if (w_payload_end) begin
                    o_result.done   = 1'b1;
                    o_result.length = w_pos_inc;
                end
            end
            default: ;
        endcase
    end

    // Advance the frame state once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_position <= '0;
            r_len_lo   <= '0;
            r_end      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_len_lo   <= n_len_lo;
            r_end      <= n_end;
        end
    end

endmodule

// ===== rtl/sentinel_length_packet_deframer.sv =====
// Timing: the result word is registered; an accepted input word passes through the input
// register, then the result register, and waits in them while the result side stalls.
// Throughput: one word per cycle while i_ready holds, one result word per input word.
// A word is taken while a finished result waits, as long as the input register is free.
// Reset (i_rst_n low at a clock edge) empties both registers, restarts the sync hunt
// and restores the configuration registers to their default values.
module sentinel_length_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_byte_taken,
    output logic [7:0] o_byte_position,
    output logic [7:0] o_byte_value,
    output logic       o_frame_done,
    output logic [8:0] o_frame_length,
    output logic       o_frame_dropped,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import slpd_pkg::*;

    t_cfg       w_cfg;
    t_result    w_result;
    logic       w_step;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;

    slpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    slpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Process the held word when the result register can take it
    assign w_step  = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_step;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_byte_taken    = r_out.taken;
    assign o_byte_position = r_out.position;
    assign o_byte_value    = r_out.value;
    assign o_frame_done    = r_out.done;
    assign o_frame_length  = r_out.length;
    assign o_frame_dropped = r_out.dropped;

endmodule

// ===== tb/deframe_checker.sv =====
`timescale 1ns / 1ps

module deframe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_byte_taken,
    input  logic [7:0] i_byte_position,
    input  logic [7:0] i_byte_value,
    input  logic       i_frame_done,
    input  logic [8:0] i_frame_length,
    input  logic       i_frame_dropped,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);
    import slpd_pkg::*;

    // Shadow copy of the registers and the frame state
    logic [7:0]  sync_first_q;
    logic [7:0]  sync_second_q;
    logic [7:0]  max_payload_q;
    t_phase      phase_q;
    logic [8:0]  offset_q;
    logic [7:0]  len_low_q;
    logic [15:0] payload_len_q;

    t_result expected_words[$];
    int      err_count = 0;

    assign o_errors = err_count;

    // Return the frame to the sync hunt
    function automatic void restart_hunt();
        phase_q  = PH_HUNT;
        offset_q = '0;
    endfunction

    // Advance the frame state by one received byte and build its result word
    function automatic t_result deframe_byte(input logic [7:0] rx);
        t_result     res;
        logic [8:0]  next_offset;
        logic [15:0] accepted_max;
        res = '0;
        // The payload limit can never exceed what the buffer and offset hold
        accepted_max = (max_payload_q > LIMIT_CAP) ? 16'(LIMIT_CAP) : 16'(max_payload_q);
        case (phase_q)
            PH_HUNT: begin
                if (rx == sync_first_q) begin
                    res.taken    = 1'b1;
                    res.position = 8'd0;
                    res.value    = rx;
                    offset_q     = 9'd1;
                    phase_q      = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                // A bad second sync byte is dropped, not retried as a first one
                if (rx == sync_second_q) begin
                    res.taken    = 1'b1;
                    res.position = 8'd1;
                    res.value    = rx;
                    offset_q     = 9'd2;
                    phase_q      = PH_HEADER;
                end else begin
                    restart_hunt();
                end
            end
            PH_HEADER: begin
                res.taken    = 1'b1;
                res.position = offset_q[7:0];
                res.value    = rx;
                if (offset_q == 9'(LEN_LO_OFFSET)) len_low_q = rx;
                next_offset = offset_q + 9'd1;
                offset_q    = next_offset;
                if (next_offset >= HEADER_LEN) begin
                    payload_len_q = {rx, len_low_q};
                    if (payload_len_q == 16'd0) begin
                        res.done   = 1'b1;
                        res.length = next_offset;
                        restart_hunt();
                    end else if (payload_len_q <= accepted_max) begin
                        phase_q = PH_PAYLOAD;
                    end else begin
                        res.dropped = 1'b1;
                        restart_hunt();
                    end
                end
            end
            default: begin
                res.taken    = 1'b1;
                res.position = offset_q[7:0];
                res.value    = rx;
                next_offset  = offset_q + 9'd1;
                offset_q     = next_offset;
                if (int'(next_offset) >= HEADER_BYTES + int'(payload_len_q)) begin
                    res.done   = 1'b1;
                    res.length = next_offset;
                    restart_hunt();
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Track register writes, predict accepted bytes, compare result words
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            sync_first_q  = SYNC_FIRST_RST;
            sync_second_q = SYNC_SECOND_RST;
            max_payload_q = MAX_PAYLOAD_RST;
            len_low_q     = '0;
            payload_len_q = '0;
            restart_hunt();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  sync_first_q  = i_cfg_data;
                    CFG_SYNC_SECOND: sync_second_q = i_cfg_data;
                    CFG_MAX_PAYLOAD: max_payload_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_words.push_back(deframe_byte(i_rx_byte));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no byte outstanding");
                    err_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("byte_taken", want.taken, i_byte_taken);
                    check_field("byte_position", want.position, i_byte_position);
                    check_field("byte_value", want.value, i_byte_value);
                    check_field("frame_done", want.done, i_frame_done);
                    check_field("frame_length", want.length, i_frame_length);
                    check_field("frame_dropped", want.dropped, i_frame_dropped);
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import slpd_pkg::*;

    localparam int         LATENCY     = 2;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte       = '0;
    logic       o_valid;
    logic       i_ready         = 1'b0;
    logic       o_byte_taken;
    logic [7:0] o_byte_position;
    logic [7:0] o_byte_value;
    logic       o_frame_done;
    logic [8:0] o_frame_length;
    logic       o_frame_dropped;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index     = '0;
    logic [7:0] i_cfg_data      = '0;

    int errors;
    int pending;
    int send_idle    = 0;
    int recv_idle    = 0;
    int hold_left    = 0;
    bit hold_request = 1'b0;
    int cycles       = 0;
    int sent         = 0;

    // Register values as the stimulus sees them
    logic [7:0] sync_a = SYNC_FIRST_RST;
    logic [7:0] sync_b = SYNC_SECOND_RST;
    logic [7:0] room   = (MAX_PAYLOAD_RST > LIMIT_CAP) ? LIMIT_CAP : MAX_PAYLOAD_RST;

    sentinel_length_packet_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_taken    (o_byte_taken),
        .o_byte_position (o_byte_position),
        .o_byte_value    (o_byte_value),
        .o_frame_done    (o_frame_done),
        .o_frame_length  (o_frame_length),
        .o_frame_dropped (o_frame_dropped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    deframe_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_byte_taken    (o_byte_taken),
        .i_byte_position (o_byte_position),
        .i_byte_value    (o_byte_value),
        .i_frame_done    (o_frame_done),
        .i_frame_length  (o_frame_length),
        .i_frame_dropped (o_frame_dropped),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random back-pressure, or a long hold when requested
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one word after an optional gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // Header with random type bytes; payload only when the length is accepted
    task automatic send_frame(input logic [15:0] plen);
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
        if (plen != 16'd0 && plen <= 16'(room))
            for (int k = 0; k < int'(plen); k++) send_byte(8'($urandom));
    endtask

    // Mostly good frames, with oversized headers, bad sync pairs and line noise
    task automatic random_traffic(input int count);
        int          stop_at;
        int          pick;
        logic [15:0] plen;
        stop_at = sent + count;
        while (sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(19) == 0) plen = 16'($urandom_range(room));
                else plen = 16'($urandom_range((room < 12) ? room : 12));
                send_frame(plen);
            end else if (pick < 80) begin
                if ($urandom_range(1) == 0) plen = 16'(room) + 16'd1;
                else plen = 16'($urandom_range(65535, int'(room) + 1));
                send_frame(plen);
            end else if (pick < 90) begin
                send_byte(sync_a);
                send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  sync_a = data;
            CFG_SYNC_SECOND: sync_b = data;
            CFG_MAX_PAYLOAD: room   = (data > LIMIT_CAP) ? LIMIT_CAP : data;
            default: ;
        endcase
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: line extremes, bad second sync, empty, oversized, one-byte frames
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_frame(16'd0);
        send_frame(16'd256);
        send_frame(16'd1);

        // Default registers, slow receiver
        send_idle = 28;
        recv_idle = 74;
        random_traffic(200);

        // Low extremes: only empty frames pass
        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        write_reg(CFG_MAX_PAYLOAD, 8'h00);
        send_idle = 74;
        recv_idle = 28;
        random_traffic(200);

        // High extremes: limit saturates; hold the receiver to fill the block
        write_reg(CFG_SYNC_FIRST, 8'hFF);
        write_reg(CFG_SYNC_SECOND, 8'h00);
        write_reg(CFG_MAX_PAYLOAD, 8'hFF);
        send_idle = 0;
        recv_idle = 0;
        hold_request = 1'b1;
        send_frame(16'd250);
        send_frame(16'd251);
        random_traffic(150);

        // Random sync pair and a small limit, hit the limit edge exactly
        write_reg(CFG_SYNC_FIRST, 8'($urandom));
        write_reg(CFG_SYNC_SECOND, 8'($urandom));
        write_reg(CFG_MAX_PAYLOAD, 8'($urandom_range(1, 40)));
        write_reg(CFG_UNUSED, 8'($urandom));
        send_frame(16'(room));
        send_frame(16'(room) + 16'd1);
        random_traffic(250);

        // Random sync pair and a wide limit
        write_reg(CFG_SYNC_FIRST, 8'($urandom));
        write_reg(CFG_SYNC_SECOND, 8'($urandom));
        write_reg(CFG_MAX_PAYLOAD, 8'($urandom_range(41, 250)));
        random_traffic(250);

        // Drain and give the verdict
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
